[rtl/assert_macros.svh]
// Assertion macros for the checker file of this project.
// Each macro expands to one labeled concurrent assertion on a rising clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is checked during reset as well.
`define ASSERT_NXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/uer_pkg.sv]
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared widths, reset values, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uer_pkg;

  // Widths of the period counter and of the configuration registers.
  localparam int CNT_W    = 16;
  localparam int PERIOD_W = 17;
  localparam int TRIG_W   = 16;
  localparam int MAX_W    = 16;
  localparam int CFG_W    = 17;
  localparam int IDX_W    = 2;

  // Result field widths.
  localparam int WIDTH_W = 16;
  localparam int US_W    = 18;
  localparam int MM_W    = 15;

  // Register reset values.
  localparam logic [PERIOD_W-1:0] RESET_PERIOD   = PERIOD_W'(26250);
  localparam logic [TRIG_W-1:0]   RESET_TRIGGER  = TRIG_W'(8);
  localparam logic [MAX_W-1:0]    RESET_ECHO_MAX = MAX_W'(11250);

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_PERIOD   = 2'd0;
  localparam logic [IDX_W-1:0] REG_TRIGGER  = 2'd1;
  localparam logic [IDX_W-1:0] REG_ECHO_MAX = 2'd2;

  // Queue between the front and back parts.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Ticks to microseconds: floor(8w/3) = (8w * ceil(2^21/3)) >> 21, exact for 8w < 2^21.
  localparam int DIV3_SHIFT = 21;
  localparam int DIV3_M_W   = 20;
  localparam logic [DIV3_M_W-1:0] DIV3_MULT = DIV3_M_W'((2 ** DIV3_SHIFT + 2) / 3);
  localparam int US_X8_W    = WIDTH_W + 3;
  localparam int US_PROD_W  = US_X8_W + DIV3_M_W;

  // Microseconds to millimetres: floor(10u/58) = floor(5u/29)
  // = (u * 5 * ceil(2^25/29)) >> 25, exact for 5u * 18 < 2^25.
  localparam int DIV29_SHIFT = 25;
  localparam int MM_M_W      = 23;
  localparam logic [MM_M_W-1:0] MM_MULT =
    MM_M_W'(5 * ((2 ** DIV29_SHIFT + 28) / 29));
  localparam int MM_PROD_W   = US_W + MM_M_W;

  // One classified tick handed from the front part to the back part.
  typedef struct packed {
    logic               trigger;
    logic               fresh;
    logic [WIDTH_W-1:0] width;
  } q_entry_t;

  // Queue status seen by the core and the back part.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/uer_front.sv]
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger front part
// Holds the configuration, runs the period counter, detects echo edges,
// measures the echo width and pushes one classified entry per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uer_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [uer_pkg::IDX_W-1:0] cfg_index,
  input  logic [uer_pkg::CFG_W-1:0] cfg_data,
  input  logic                      take,
  input  logic                      echo_level,
  output logic                      push,
  output uer_pkg::q_entry_t         push_entry
);

  logic [uer_pkg::PERIOD_W-1:0] period_ticks;
  logic [uer_pkg::TRIG_W-1:0]   trigger_ticks;
  logic [uer_pkg::MAX_W-1:0]    width_limit;

  logic [uer_pkg::CNT_W-1:0]    tick_counter;
  logic                         echo_previous;
  logic                         awaiting_fall;
  logic [uer_pkg::CNT_W-1:0]    rise_time;
  logic [uer_pkg::WIDTH_W-1:0]  last_width;

  logic [uer_pkg::CNT_W-1:0]    tick_counter_next;
  logic [uer_pkg::CNT_W:0]      count_inc;
  logic                         trig;
  logic                         echo_edge;
  logic [uer_pkg::CNT_W+1:0]    span;
  logic                         width_ok;
  logic                         fresh;
  logic [uer_pkg::WIDTH_W-1:0]  last_width_next;

  // Counter advance: wrap at the period or at the counter's own width.
  assign count_inc = {1'b0, tick_counter} + (uer_pkg::CNT_W+1)'(1);
  assign tick_counter_next = (count_inc >= period_ticks) ? '0 : count_inc[uer_pkg::CNT_W-1:0];

  // Trigger drive and edge detection use the count before it advances.
  assign trig      = tick_counter < trigger_ticks;
  assign echo_edge = echo_level != echo_previous;

  // Echo width, wrapping across the period when the fall count is below the rise.
  always_comb begin
    if (tick_counter >= rise_time) begin
      span = {2'b00, tick_counter} - {2'b00, rise_time};
    end else begin
      span = {2'b00, tick_counter} + {1'b0, period_ticks} - {2'b00, rise_time};
    end
  end
  assign width_ok        = span <= {2'b00, width_limit};
  assign fresh           = echo_edge && awaiting_fall && width_ok;
  assign last_width_next = fresh ? span[uer_pkg::WIDTH_W-1:0] : last_width;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks  <= uer_pkg::RESET_PERIOD;
      trigger_ticks <= uer_pkg::RESET_TRIGGER;
      width_limit   <= uer_pkg::RESET_ECHO_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        uer_pkg::REG_PERIOD:   period_ticks  <= cfg_data;
        uer_pkg::REG_TRIGGER:  trigger_ticks <= cfg_data[uer_pkg::TRIG_W-1:0];
        uer_pkg::REG_ECHO_MAX: width_limit   <= cfg_data[uer_pkg::MAX_W-1:0];
        default: ;
      endcase
    end
  end

  // Tick state, advanced once per accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter  <= '0;
      echo_previous <= 1'b0;
      awaiting_fall <= 1'b0;
      rise_time     <= '0;
      last_width    <= '0;
    end else if (take) begin
      tick_counter  <= tick_counter_next;
      echo_previous <= echo_level;
      last_width    <= last_width_next;
      if (echo_edge) begin
        awaiting_fall <= !awaiting_fall;
        if (!awaiting_fall) begin
          rise_time <= tick_counter;
        end
      end
    end
  end

  // Entry for the back part.
  assign push             = take;
  assign push_entry.trigger = trig;
  assign push_entry.fresh   = fresh;
  assign push_entry.width   = last_width_next;

endmodule

[rtl/uer_queue.sv]
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger queue
// Small first-in first-out buffer that decouples the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uer_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  uer_pkg::q_entry_t   push_entry,
  input  logic                pop,
  output uer_pkg::q_entry_t   head,
  output uer_pkg::q_status_t  status
);

  uer_pkg::q_entry_t                entries [uer_pkg::Q_DEPTH];
  logic [uer_pkg::Q_PTR_W-1:0]      wr_ptr;
  logic [uer_pkg::Q_PTR_W-1:0]      rd_ptr;
  logic [uer_pkg::Q_CNT_W-1:0]      fill;

  // Entry storage; no reset needed for the payload.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + uer_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + uer_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + uer_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - uer_pkg::Q_CNT_W'(1);
      end
    end
  end

  assign head         = entries[rd_ptr];
  assign status.full  = fill == uer_pkg::Q_CNT_W'(uer_pkg::Q_DEPTH);
  assign status.empty = fill == '0;

endmodule

[rtl/uer_back.sv]
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger back part
// Converts the echo width to microseconds and millimetres in two stages
// and holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uer_back (
  input  logic                        clk,
  input  logic                        rst,
  input  uer_pkg::q_entry_t           head,
  input  uer_pkg::q_status_t          status,
  output logic                        pop,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic                        trigger_level,
  output logic                        new_measurement,
  output logic [uer_pkg::WIDTH_W-1:0] width_ticks,
  output logic [uer_pkg::US_W-1:0]    width_us,
  output logic [uer_pkg::MM_W-1:0]    distance_mm
);

  logic                            advance;
  logic                            s1_valid;
  uer_pkg::q_entry_t               s1_entry;
  logic [uer_pkg::US_W-1:0]        s1_us;
  logic [uer_pkg::US_PROD_W-1:0]   us_prod;
  logic [uer_pkg::MM_PROD_W-1:0]   mm_prod;

  // The whole back part moves when the output register is free or being taken.
  assign advance = !result_valid || result_ready;
  assign pop     = advance && !status.empty;

  // Stage one: ticks times 8 divided by 3 through a reciprocal multiply.
  assign us_prod = uer_pkg::US_PROD_W'({head.width, 3'b000}) *
                   uer_pkg::US_PROD_W'(uer_pkg::DIV3_MULT);

  // Stage two: microseconds times 10 divided by 58 through a reciprocal multiply.
  assign mm_prod = uer_pkg::MM_PROD_W'(s1_us) * uer_pkg::MM_PROD_W'(uer_pkg::MM_MULT);

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= !status.empty;
      result_valid <= s1_valid;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_entry        <= head;
      s1_us           <= us_prod[uer_pkg::DIV3_SHIFT +: uer_pkg::US_W];
      trigger_level   <= s1_entry.trigger;
      new_measurement <= s1_entry.fresh;
      width_ticks     <= s1_entry.width;
      width_us        <= s1_us;
      distance_mm     <= mm_prod[uer_pkg::DIV29_SHIFT +: uer_pkg::MM_W];
    end
  end

endmodule

[rtl/ultrasonic_echo_ranger_core.sv]
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger core
// Pulse-width ranging on a timebase tick stream with trigger generation.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the echo channel (echo_valid/echo_ready, field echo_level)
//   is one timebase tick carrying the sampled echo pin level. Every request
//   yields exactly one result on the result channel (result_valid/result_ready)
//   with the trigger drive, a new-measurement flag, and the last accepted echo
//   width in ticks, microseconds and millimetres.
//   The configuration port (cfg_we, cfg_index, cfg_data) writes the period,
//   trigger length and longest accepted echo width; write it only while idle.
//   Results pass through the queue, the stage-one register and the output
//   register. One request is accepted every cycle while the queue has room;
//   the rate is set by the one-tick counter and edge update in the front part.
//   When the receiver stalls, the conversion stages and output register hold,
//   a four-entry queue absorbs further requests, and echo_ready drops when the
//   queue is full. Reset restores the register defaults, clears the counter,
//   the phase flag and the kept width, and empties the queue and the stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [uer_pkg::IDX_W-1:0]   cfg_index,
  input  logic [uer_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        echo_valid,
  output logic                        echo_ready,
  input  logic                        echo_level,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic                        trigger_level,
  output logic                        new_measurement,
  output logic [uer_pkg::WIDTH_W-1:0] width_ticks,
  output logic [uer_pkg::US_W-1:0]    width_us,
  output logic [uer_pkg::MM_W-1:0]    distance_mm
);

  logic               take;
  logic               push;
  logic               pop;
  uer_pkg::q_entry_t  push_entry;
  uer_pkg::q_entry_t  head;
  uer_pkg::q_status_t status;

  // A request is taken whenever the queue has room.
  assign echo_ready = !status.full;
  assign take       = echo_valid && echo_ready;

  uer_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .take       (take),
    .echo_level (echo_level),
    .push       (push),
    .push_entry (push_entry)
  );

  uer_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  uer_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .status          (status),
    .pop             (pop),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .trigger_level   (trigger_level),
    .new_measurement (new_measurement),
    .width_ticks     (width_ticks),
    .width_us        (width_us),
    .distance_mm     (distance_mm)
  );

endmodule

[rtl/uer_checker.sv]
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger checker
// Port-level assertions on the result channel and the unit conversions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uer_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        echo_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic                        trigger_level,
  input logic                        new_measurement,
  input logic [uer_pkg::WIDTH_W-1:0] width_ticks,
  input logic [uer_pkg::US_W-1:0]    width_us,
  input logic [uer_pkg::MM_W-1:0]    distance_mm
);

  logic [20:0] us_x3;
  logic [20:0] ticks_x8;
  logic [21:0] mm_x58;
  logic [21:0] us_x10;
  logic        stalled;
  logic [uer_pkg::WIDTH_W+uer_pkg::US_W+uer_pkg::MM_W+1:0] payload;

  // Scaled values so the conversions can be checked without dividing.
  assign us_x3    = 21'(width_us) * 21'd3;
  assign ticks_x8 = 21'(width_ticks) * 21'd8;
  assign mm_x58   = 22'(distance_mm) * 22'd58;
  assign us_x10   = 22'(width_us) * 22'd10;
  assign stalled  = result_valid && !result_ready;
  assign payload  = {trigger_level, new_measurement, width_ticks, width_us, distance_mm};

  // A stalled result stays offered with the same payload.
  `ASSERT_NXT(a_result_hold, clk, rst, stalled, result_valid && $stable(payload))

  // Microseconds are ticks times 8 divided by 3, truncated.
  `ASSERT_IMP(a_us_scale, clk, rst, result_valid, us_x3 <= ticks_x8 && ticks_x8 < us_x3 + 21'd3)

  // Millimetres are microseconds times 10 divided by 58, truncated.
  `ASSERT_IMP(a_mm_scale, clk, rst, result_valid, mm_x58 <= us_x10 && us_x10 < mm_x58 + 22'd58)

  // Reset leaves no result offered and the input open.
  `ASSERT_NXT_ALWAYS(a_reset_clear, clk, rst, !result_valid && echo_ready)

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (.*);
